// ===== rtl/core/pinhole_ray_direction_assert.svh =====
// Assertion macros used by the ray direction top level.
`ifndef PINHOLE_RAY_DIRECTION_ASSERT_SVH
`define PINHOLE_RAY_DIRECTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/prd_pkg.sv =====
// Types, widths and helpers shared by the ray direction pipeline.
package prd_pkg;

   localparam int CompW  = 21;
   localparam int RegW   = 63;
   localparam int PixW   = 16;
   localparam int ProdW  = 38;
   localparam int VecW   = 39;
   localparam int MagW   = 38;
   localparam int NormW  = 31;
   localparam int MsbW   = 6;
   localparam int SqW    = 62;
   localparam int SumW   = 64;
   localparam int RootW  = 32;
   localparam int RemW   = 34;
   localparam int QW     = 15;
   localparam int DirW   = 16;
   localparam int FracW  = 14;
   localparam int NumW   = 46;
   localparam int CornerShift = 6;

   typedef enum logic [1:0] {
      REG_CORNER = 2'd0,
      REG_RIGHT  = 2'd1,
      REG_DOWN   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } flags_type;

   function automatic logic signed [CompW-1:0] comp_of(logic [RegW-1:0] r, int idx);
      return $signed(r[idx*CompW +: CompW]);
   endfunction

   function automatic logic signed [ProdW-1:0] mul_step(logic signed [CompW-1:0] s,
                                                        logic [PixW-1:0] p);
      logic signed [ProdW-1:0] se;
      logic signed [ProdW-1:0] pe;
      se = $signed({{(ProdW-CompW){s[CompW-1]}}, s});
      pe = $signed({{(ProdW-PixW){1'b0}}, p});
      return se * pe;
   endfunction

endpackage

// ===== rtl/core/prd_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module prd_isqrt import prd_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  logic              in_vld,
   input  logic [SumW-1:0]   in_s,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [RootW-1:0]  out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int Steps = RootW;

   logic              vld_ff  [Steps];
   logic [RemW-1:0]   rem_ff  [Steps];
   logic [RootW-1:0]  root_ff [Steps];
   logic [SumW-1:0]   s_ff    [Steps];
   logic [SIDE_W-1:0] side_ff [Steps];

   logic              p_vld  [Steps];
   logic [RemW-1:0]   p_rem  [Steps];
   logic [RootW-1:0]  p_root [Steps];
   logic [SumW-1:0]   p_s    [Steps];
   logic [SIDE_W-1:0] p_side [Steps];

   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic [RemW+1:0]  rem_sh;
      logic [RemW+1:0]  trial;
      logic [RemW-1:0]  rem_in;
      logic [RootW-1:0] root_in;

      if (k == 0) begin : g_first
         assign p_vld[k]  = in_vld;
         assign p_rem[k]  = '0;
         assign p_root[k] = '0;
         assign p_s[k]    = in_s;
         assign p_side[k] = in_side;
      end else begin : g_next
         assign p_vld[k]  = vld_ff[k-1];
         assign p_rem[k]  = rem_ff[k-1];
         assign p_root[k] = root_ff[k-1];
         assign p_s[k]    = s_ff[k-1];
         assign p_side[k] = side_ff[k-1];
      end

      always_comb begin
         rem_sh = {p_rem[k], p_s[k][SumW-1 -: 2]};
         trial  = {p_root[k], 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = RemW'(rem_sh - trial);
            root_in = {p_root[k][RootW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RemW-1:0];
            root_in = {p_root[k][RootW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ce) begin
            vld_ff[k] <= p_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            s_ff[k]    <= {p_s[k][SumW-3:0], 2'b00};
            side_ff[k] <= p_side[k];
         end
      end
   end

   assign out_vld  = vld_ff[Steps-1];
   assign out_root = root_ff[Steps-1];
   assign out_side = side_ff[Steps-1];

endmodule

// ===== rtl/core/prd_div.sv =====
// Pipelined three-lane rounded divider, one quotient bit per later stage.
module prd_div import prd_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       ce,
   input  logic                       in_vld,
   input  logic [RootW-1:0]           in_r,
   input  logic [2:0][NormW-1:0]      in_a,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_vld,
   output logic [2:0][QW-1:0]         out_q,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int Steps = QW + 1;

   logic                  vld_ff  [Steps];
   logic [RootW-1:0]      r_ff    [Steps];
   logic [2:0][NumW-1:0]  num_ff  [Steps];
   logic [2:0][QW-1:0]    q_ff    [Steps];
   logic [SIDE_W-1:0]     side_ff [Steps];

   logic [2:0][NumW-1:0]  num0_in;

   // The first stage adds half the divisor so that truncation rounds to nearest.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num0_in[i] = NumW'({in_a[i], {FracW{1'b0}}}) + NumW'(in_r >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (ce) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         r_ff[0]    <= in_r;
         num_ff[0]  <= num0_in;
         q_ff[0]    <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 1; j < Steps; j++) begin : g_step
      localparam int Bit = QW - j;
      logic [NumW-1:0]      dvs;
      logic [2:0][NumW-1:0] num_in;
      logic [2:0][QW-1:0]   q_in;

      always_comb begin
         dvs = NumW'(r_ff[j-1]) << Bit;
         for (int i = 0; i < 3; i++) begin
            if (num_ff[j-1][i] >= dvs) begin
               num_in[i] = num_ff[j-1][i] - dvs;
               q_in[i]   = {q_ff[j-1][i][QW-2:0], 1'b1};
            end else begin
               num_in[i] = num_ff[j-1][i];
               q_in[i]   = {q_ff[j-1][i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (ce) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            r_ff[j]    <= r_ff[j-1];
            num_ff[j]  <= num_in;
            q_ff[j]    <= q_in;
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign out_vld  = vld_ff[Steps-1];
   assign out_q    = q_ff[Steps-1];
   assign out_side = side_ff[Steps-1];

endmodule

// ===== rtl/core/pinhole_ray_direction.sv =====
// Pinhole camera ray direction generator, top level.
//
// The req_ stream carries one pixel position per beat and the rsp_ stream
// returns one unit ray direction per beat, in the same order. The csr_ port
// writes the corner offset, right step and down step registers; the user must
// write them only while the block is idle, as the block does not enforce it.
// The block takes one beat every cycle while req_tready is high. Its
// pipeline has one register stage per multiply, add, maximum, leading one,
// shift, square and sum step, one per bit of the 32-bit square root, a
// rounding stage, one per bit of the 15-bit quotient, then a sign stage
// and the output register. Reset clears the three registers and empties
// the pipeline and the output stage. When the receiver stalls, a result
// waiting at the output is held and one more finished result moves into a
// skid register; the pipeline then freezes and req_tready drops until the
// skid register drains, so no beat is lost or repeated. A zero vector
// gives a zero direction with the degenerate flag set in rsp_tuser.
`include "pinhole_ray_direction_assert.svh"

module pinhole_ray_direction import prd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2*PixW-1:0]     req_tdata,   // pixel_x, pixel_y
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [3*DirW-1:0]     rsp_tdata,   // dir_x, dir_y, dir_z
   output logic [0:0]            rsp_tuser,   // degenerate
   input  logic                  csr_we,
   input  logic [1:0]            csr_addr,
   input  logic [RegW-1:0]       csr_wdata
);

   localparam int NormTop = NormW - 1;
   localparam int SideW   = 3 * NormW + 4;

   typedef struct packed {
      logic                  degen;
      logic [2:0][DirW-1:0]  dir;
   } result_type;

   logic [RegW-1:0] corner_ff;
   logic [RegW-1:0] right_ff;
   logic [RegW-1:0] down_ff;

   logic ce;

   logic                        a_vld_ff;
   logic signed [CompW-1:0]     c_a_ff  [3];
   logic signed [ProdW-1:0]     pr_a_ff [3];
   logic signed [ProdW-1:0]     pd_a_ff [3];

   logic                        b_vld_ff;
   logic [2:0][MagW-1:0]        mag_b_ff;
   logic [2:0]                  neg_b_ff;
   logic [2:0][MagW-1:0]        mag_b_in;
   logic [2:0]                  neg_b_in;

   logic                        c_vld_ff;
   logic [2:0][MagW-1:0]        mag_c_ff;
   logic [MagW-1:0]             max_c_ff;
   logic [2:0]                  neg_c_ff;
   logic [MagW-1:0]             max_c_in;

   logic                        d_vld_ff;
   logic [2:0][MagW-1:0]        mag_d_ff;
   logic [MsbW-1:0]             msb_d_ff;
   logic [2:0]                  neg_d_ff;
   logic                        degen_d_ff;
   logic [MsbW-1:0]             msb_d_in;

   logic                        e_vld_ff;
   logic [2:0][NormW-1:0]       a_e_ff;
   logic                        e_flags_vld;
   flags_type                   flags_e_ff;
   logic [2:0][NormW-1:0]       a_e_in;

   logic                        f_vld_ff;
   logic [2:0][NormW-1:0]       a_f_ff;
   logic [2:0][SqW-1:0]         sq_f_ff;
   flags_type                   flags_f_ff;

   logic                        g_vld_ff;
   logic [2:0][NormW-1:0]       a_g_ff;
   logic [SumW-1:0]             sum_g_ff;
   flags_type                   flags_g_ff;

   logic                        sq_vld;
   logic [RootW-1:0]            sq_root;
   logic [SideW-1:0]            sq_side;
   logic [2:0][NormW-1:0]       sq_a;
   flags_type                   sq_flags;

   logic                        dv_vld;
   logic [2:0][QW-1:0]          dv_q;
   flags_type                   dv_flags;

   logic                        fin_vld_ff;
   result_type                  fin_ff;
   result_type                  fin_in;

   logic                        out_vld_ff;
   result_type                  out_ff;
   logic                        skid_vld_ff;
   result_type                  skid_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff <= '0;
         right_ff  <= '0;
         down_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            REG_CORNER: corner_ff <= csr_wdata;
            REG_RIGHT:  right_ff  <= csr_wdata;
            REG_DOWN:   down_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ce         = !skid_vld_ff;
   assign req_tready = ce;

   // Stage A: step products.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (ce) begin
         a_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            c_a_ff[i]  <= comp_of(corner_ff, i);
            pr_a_ff[i] <= mul_step(comp_of(right_ff, i), req_tdata[PixW-1:0]);
            pd_a_ff[i] <= mul_step(comp_of(down_ff, i), req_tdata[2*PixW-1:PixW]);
         end
      end
   end

   // Stage B: vector sum, split into sign and magnitude.
   always_comb begin
      logic signed [VecW-1:0] v;
      for (int i = 0; i < 3; i++) begin
         v = $signed({{(VecW-CompW-CornerShift){c_a_ff[i][CompW-1]}}, c_a_ff[i],
                      {CornerShift{1'b0}}})
           + $signed({pr_a_ff[i][ProdW-1], pr_a_ff[i]})
           + $signed({pd_a_ff[i][ProdW-1], pd_a_ff[i]});
         neg_b_in[i] = v[VecW-1];
         mag_b_in[i] = neg_b_in[i] ? MagW'(-v) : MagW'(v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (ce) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         mag_b_ff <= mag_b_in;
         neg_b_ff <= neg_b_in;
      end
   end

   // Stage C: largest magnitude.
   always_comb begin
      max_c_in = mag_b_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (mag_b_ff[i] > max_c_in) begin
            max_c_in = mag_b_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (ce) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         mag_c_ff <= mag_b_ff;
         max_c_ff <= max_c_in;
         neg_c_ff <= neg_b_ff;
      end
   end

   // Stage D: leading one of the largest magnitude.
   always_comb begin
      msb_d_in = '0;
      for (int j = 0; j < MagW; j++) begin
         if (max_c_ff[j]) begin
            msb_d_in = MsbW'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (ce) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         mag_d_ff   <= mag_c_ff;
         msb_d_ff   <= msb_d_in;
         neg_d_ff   <= neg_c_ff;
         degen_d_ff <= (max_c_ff == '0);
      end
   end

   // Stage E: shift so that the largest magnitude has its top bit at 30.
   always_comb begin
      logic [MagW-1:0] shifted;
      for (int i = 0; i < 3; i++) begin
         if (msb_d_ff > MsbW'(NormTop)) begin
            shifted = mag_d_ff[i] >> (msb_d_ff - MsbW'(NormTop));
         end else begin
            shifted = mag_d_ff[i] << (MsbW'(NormTop) - msb_d_ff);
         end
         a_e_in[i] = shifted[NormW-1:0];
      end
   end

   assign e_flags_vld = e_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (ce) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_e_ff           <= a_e_in;
         flags_e_ff.neg   <= neg_d_ff;
         flags_e_ff.degen <= degen_d_ff;
      end
   end

   // Stage F: squares.
   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (ce) begin
         f_vld_ff <= e_flags_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            sq_f_ff[i] <= {{(SqW-NormW){1'b0}}, a_e_ff[i]}
                        * {{(SqW-NormW){1'b0}}, a_e_ff[i]};
         end
         a_f_ff     <= a_e_ff;
         flags_f_ff <= flags_e_ff;
      end
   end

   // Stage G: sum of squares.
   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (ce) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sum_g_ff   <= SumW'(sq_f_ff[0]) + SumW'(sq_f_ff[1]) + SumW'(sq_f_ff[2]);
         a_g_ff     <= a_f_ff;
         flags_g_ff <= flags_f_ff;
      end
   end

   prd_isqrt #(
      .SIDE_W (SideW)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_vld   (g_vld_ff),
      .in_s     (sum_g_ff),
      .in_side  ({a_g_ff, flags_g_ff}),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   assign {sq_a, sq_flags} = sq_side;

   prd_div #(
      .SIDE_W ($bits(flags_type))
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_vld   (sq_vld),
      .in_r     (sq_root),
      .in_a     (sq_a),
      .in_side  (sq_flags),
      .out_vld  (dv_vld),
      .out_q    (dv_q),
      .out_side (dv_flags)
   );

   // Final stage: apply signs and the zero-vector case.
   always_comb begin
      fin_in.degen = dv_flags.degen;
      for (int i = 0; i < 3; i++) begin
         if (dv_flags.degen) begin
            fin_in.dir[i] = '0;
         end else if (dv_flags.neg[i]) begin
            fin_in.dir[i] = -{1'b0, dv_q[i]};
         end else begin
            fin_in.dir[i] = {1'b0, dv_q[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (ce) begin
         fin_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         fin_ff <= fin_in;
      end
   end

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (out_vld_ff && !rsp_tready) begin
         skid_vld_ff <= fin_vld_ff;
      end else begin
         out_vld_ff <= fin_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_tready) begin
            out_ff <= skid_ff;
         end
      end else if (out_vld_ff && !rsp_tready) begin
         skid_ff <= fin_ff;
      end else begin
         out_ff <= fin_ff;
      end
   end

   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = {out_ff.dir[2], out_ff.dir[1], out_ff.dir[0]};
   assign rsp_tuser[0] = out_ff.degen;

   `PRD_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_vld_ff, out_vld_ff, "skid full while output empty")
   `PRD_ASSERT_IMPLY(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "degenerate beat with nonzero direction")
   `PRD_ASSERT_IMPLY(a_unit_range, clock, reset, rsp_tvalid, ($signed(out_ff.dir[0]) <= 16384) && ($signed(out_ff.dir[0]) >= -16384), "direction component out of range")
   `PRD_ASSERT_NEXT(a_frozen_pipe, clock, reset, !req_tready, $stable(fin_vld_ff), "pipeline moved while frozen")

endmodule

// ===== verif/pinhole_ray_direction_tb.sv =====
// Self-checking testbench for the pinhole ray direction generator.
module pinhole_ray_direction_tb;
   import prd_pkg::*;

   typedef struct {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic               degenerate;
   } ray_dir_type;

   class ray_scoreboard;
      logic [62:0] corner, right, down;
      ray_dir_type pending[$];
      int          errors;
      int          matched;
      int          degen_seen;

      function void reset_regs();
         corner = '0;
         right = '0;
         down = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [62:0] val);
         case (idx)
            REG_CORNER: corner = val;
            REG_RIGHT: right = val;
            REG_DOWN: down = val;
            default: ;
         endcase
      endfunction

      function logic [63:0] root_of(logic [63:0] s);
         logic [63:0] res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > s) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (s >= res + bitv) begin
               s = s - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function void note_pixel(logic [15:0] px, logic [15:0] py);
         logic signed [63:0] v;
         logic [63:0] mag[3];
         logic neg[3];
         logic [63:0] m, s, r, q;
         ray_dir_type d;
         logic signed [15:0] outs[3];
         m = 0;
         for (int i = 0; i < 3; i++) begin
            v = $signed(corner[i*21 +: 21]) * 64
              + $signed(right[i*21 +: 21]) * $signed({48'd0, px})
              + $signed(down[i*21 +: 21]) * $signed({48'd0, py});
            neg[i] = v < 0;
            mag[i] = neg[i] ? -v : v;
            if (mag[i] > m) m = mag[i];
         end
         if (m == 0) begin
            d = '{0, 0, 0, 1'b1};
         end else begin
            while (m >= (64'd1 << 31)) begin
               m = m >> 1;
               for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            end
            while (m < (64'd1 << 30)) begin
               m = m << 1;
               for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            r = root_of(s);
            for (int i = 0; i < 3; i++) begin
               q = ((mag[i] << 14) + (r >> 1)) / r;
               outs[i] = neg[i] ? -q[15:0] : q[15:0];
            end
            d = '{outs[0], outs[1], outs[2], 1'b0};
         end
         pending.insert(pending.size(), d);
      endfunction

      function void check_ray(logic [47:0] data, logic degen);
         ray_dir_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat %h", data);
            errors++;
            return;
         end
         e = pending.pop_front();
         matched++;
         if (degen) degen_seen++;
         if (data[15:0] !== e.dir_x) begin
            $error("dir_x expected %0d actual %0d", e.dir_x, $signed(data[15:0]));
            errors++;
         end
         if (data[31:16] !== e.dir_y) begin
            $error("dir_y expected %0d actual %0d", e.dir_y, $signed(data[31:16]));
            errors++;
         end
         if (data[47:32] !== e.dir_z) begin
            $error("dir_z expected %0d actual %0d", e.dir_z, $signed(data[47:32]));
            errors++;
         end
         if (degen !== e.degenerate) begin
            $error("degenerate expected %0d actual %0d", e.degenerate, degen);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [1:0]  csr_addr = '0;
   logic [62:0] csr_wdata = '0;

   ray_scoreboard sb = new();
   int cycles = 0;
   int sent = 0;
   int sink_idle_pct = 15;
   int src_idle_pct = 15;
   bit hold_sink = 0;

   pinhole_ray_direction dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_ray(rsp_tdata, rsp_tuser[0]);
      rsp_tready <= !hold_sink && ($urandom_range(99) >= sink_idle_pct);
   end

   task automatic write_csr(csr_index_type idx, logic [62:0] val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [15:0] px, logic [15:0] py);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pixel(px, py);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   function automatic logic [20:0] rand_comp(int mode);
      case (mode)
         0: return 21'h0FFFFF;
         1: return 21'h100000;
         2: return 21'($urandom_range(2047) - 1024);
         default: return 21'($urandom);
      endcase
   endfunction

   function automatic logic [62:0] rand_reg(int mode);
      return {rand_comp(mode), rand_comp(mode), rand_comp(mode)};
   endfunction

   task automatic random_pixels(int n);
      logic [15:0] px, py;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: begin px = 16'($urandom); py = 16'($urandom); end
            1: begin px = 16'($urandom_range(15)); py = 16'($urandom_range(15)); end
            default: begin
               px = 16'($urandom_range(4095));
               py = 16'($urandom_range(4095));
            end
         endcase
         send_pixel(px, py);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // With all registers cleared every pixel gives the zero vector.
      send_pixel(16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'hFFFF);
      drain();
      write_csr(REG_CORNER, {21'd0, 21'd0, 21'h100000});
      write_csr(REG_RIGHT, {21'd0, 21'd0, 21'd1});
      write_csr(REG_DOWN, {21'h0FFFFF, 21'h100000, 21'h1FFFFF});
      send_pixel(16'h0000, 16'h0000);
      send_pixel(16'hFFFF, 16'h0000);
      send_pixel(16'h0000, 16'hFFFF);
      send_pixel(16'hFFFF, 16'hFFFF);
      send_pixel(16'h8000, 16'h0001);
      drain();
      // Corner cancels the right step exactly at one pixel: zero vector.
      write_csr(REG_CORNER, {21'd0, 21'd0, 21'h1FFFFF});
      write_csr(REG_DOWN, 63'd0);
      send_pixel(16'd64, 16'd0);
      send_pixel(16'd63, 16'd0);
      send_pixel(16'd65, 16'd5);
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(REG_CORNER, rand_reg(phase % 4));
         write_csr(REG_RIGHT, rand_reg((phase + 1) % 4));
         write_csr(REG_DOWN, rand_reg((phase + 2) % 4));
         src_idle_pct = (phase == 2) ? 0 : 15;
         sink_idle_pct = (phase == 2) ? 0 : 15;
         if (phase == 3) begin
            fork
               begin
                  hold_sink = 1;
                  repeat (200) @(posedge clock);
                  hold_sink = 0;
               end
               random_pixels(85);
            join
         end else begin
            random_pixels(80);
         end
         drain();
      end
      $display("Sent %0d pixels over several register settings; %0d results checked, %0d zero.",
               sent, sb.matched, sb.degen_seen);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ===== pinhole_ray_direction.f =====
+incdir+rtl/core
rtl/core/prd_pkg.sv
rtl/core/prd_isqrt.sv
rtl/core/prd_div.sv
rtl/core/pinhole_ray_direction.sv
verif/pinhole_ray_direction_tb.sv
